[src/pps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// shared widths, defaults and types of the prime sieve block
// ----------------------------------------------------------------------------
package pps_pkg;

   // width of one candidate number
   localparam int VALUE_WIDTH = 16;

   // default chain length
   localparam int NUM_CELLS_DEFAULT = 16;

   // status of the shared remainder unit toward the sequencer
   typedef struct packed {
      logic done;   // one-cycle pulse, remainder valid
      logic zero;   // remainder is zero
   } rem_status_type;

endpackage : pps_pkg
`default_nettype wire

[src/pipelined_prime_sieve.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipelined_prime_sieve
// prime sieve over a chain of kept primes, checked by one shared remainder unit
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, req_value         | in
//  rsp     | rsp_valid, rsp_stall, rsp_prime_value,  | out
//          | rsp_overflow                            |
//
//  an item is checked against the filled cells in order; each cell costs a ram
//  read of the kept prime, the shift-subtract steps of the remainder unit and
//  a decision; an item that survives every cell is then reported, and an item
//  that some kept prime divides is dropped
//  req_stall is high from the cycle after an accept until the item is done
//  the result sits in an output register, so the next item may be taken
//  while rsp_stall holds the previous result; a reporting item waits in its
//  last cycle while that register is still held
//  reset clears the fill count and the handshakes; the prime ram is not
//  cleared since only filled cells are ever read
//
module pipelined_prime_sieve
   import pps_pkg::*;
#(
   parameter int NUM_CELLS = NUM_CELLS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0]      rsp_prime_value,
   output logic                        rsp_overflow
);

   localparam int AddrWidth  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int CountWidth = $clog2(NUM_CELLS + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;   // waiting for an item
   localparam logic [1:0] S_LOAD = 2'd1;   // kept prime on ram output, start unit
   localparam logic [1:0] S_DIV  = 2'd2;   // remainder in progress
   localparam logic [1:0] S_EMIT = 2'd3;   // item survived, report it

   logic [1:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [AddrWidth-1:0]   idx_ff, idx_in;
   logic [CountWidth-1:0]  filled_ff, filled_in;
   logic [CountWidth-1:0]  idx_next;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   req_take;
   logic                   out_free;
   logic                   chain_full;
   logic                   rem_start;
   rem_status_type         rem_status;
   logic                   ram_wr_en;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign chain_full = (filled_ff == CountWidth'(NUM_CELLS));
   assign idx_next   = CountWidth'(idx_ff) + CountWidth'(1);
   assign rem_start  = (state_ff == S_LOAD);

   // sequencer: walk the filled cells one at a time through the shared unit
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      filled_in    = filled_ff;
      ram_wr_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               value_in = req_value;
               idx_in   = '0;
               // empty chain: first item is captured right away
               state_in = (filled_ff == '0) ? S_EMIT : S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  // kept prime divides the item, drop it
                  state_in = S_IDLE;
               end else if (idx_next == filled_ff) begin
                  state_in = S_EMIT;
               end else begin
                  idx_in   = idx_next[AddrWidth-1:0];
                  state_in = S_LOAD;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_ovf_in   = chain_full;
               if (!chain_full) begin
                  // capture into the first empty cell
                  ram_wr_en = 1'b1;
                  filled_in = filled_ff + CountWidth'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // kept primes; read address is the next index so data is ready in S_LOAD
   pps_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (NUM_CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (filled_ff[AddrWidth-1:0]),
      .wr_data (value_ff),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   // shared remainder unit, item modulo kept prime
   pps_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (value_ff),
      .divisor  (ram_rd_data),
      .status   (rem_status)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule : pipelined_prime_sieve
`default_nettype wire

[src/pps_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : pps_ram
`default_nettype wire

[src/pps_rem_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_rem_unit
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module pps_rem_unit
   import pps_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [VALUE_WIDTH-1:0] divisor,
   output rem_status_type              status
);

   localparam int CntWidth = $clog2(VALUE_WIDTH);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] num_ff, num_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH:0]   trial;

   // a zero divisor never subtracts anything, so the remainder is the dividend
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[VALUE_WIDTH-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         num_in = {num_ff[VALUE_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = VALUE_WIDTH'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
         cnt_in = cnt_ff + CntWidth'(1);
         if (cnt_ff == CntWidth'(VALUE_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

endmodule : pps_rem_unit
`default_nettype wire

[src/pps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_checker
// port-level checks of the prime sieve, bound to the top level
// ----------------------------------------------------------------------------
module pps_checker
   import pps_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [VALUE_WIDTH-1:0] rsp_prime_value,
   input wire logic                   rsp_overflow
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // an accepted item keeps the block busy in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken back to back");

   // a result never comes in the cycle right after its item was taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_prime_value) && $stable(rsp_overflow)))
      else $error("stalled result changed");

endmodule : pps_checker

bind pipelined_prime_sieve pps_checker u_pps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_prime_value (rsp_prime_value),
   .rsp_overflow    (rsp_overflow)
);
`default_nettype wire

[bench/pipelined_prime_sieve_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipelined_prime_sieve_test
// self-checking bench for the prime sieve chain
// ----------------------------------------------------------------------------
// a clocked driver feeds candidate numbers from a pending queue in random
// bursts; a local model of the sieve chain predicts every captured prime and
// every survivor of the full chain; a clocked monitor pops those predictions
// in order and compares them field by field, while the receiver stalls on a
// pattern of its own, including one long hold-off
// ----------------------------------------------------------------------------
module pipelined_prime_sieve_test;
   import pps_pkg::*;

   localparam int CELLS       = NUM_CELLS_DEFAULT;
   localparam int TAIL_CYCLES = 2 + 18 * CELLS + 20;   // slowest item plus margin
   localparam int HOLD_CYCLES = 3000;                  // long receiver hold-off
   localparam int RANDOM_ITEMS = 1525;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // one candidate waiting to be offered; drain_first makes the driver wait
   // until every predicted result has arrived before offering it
   typedef struct {
      value_type value;
      logic      drain_first;
   } candidate_type;

   typedef struct {
      value_type prime_value;
      logic      overflow;
   } sieve_result_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   value_type req_value = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b1;
   value_type rsp_prime_value;
   logic      rsp_overflow;

   pipelined_prime_sieve #(
      .NUM_CELLS (CELLS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_value (rsp_prime_value),
      .rsp_overflow    (rsp_overflow)
   );

   // bench state
   candidate_type    pending_candidates[$];
   sieve_result_type expected_primes[$];
   value_type        kept_prime[CELLS];
   int               fill_count = 0;
   int               error_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // sieve chain model: drop on the first kept prime that divides the number,
   // capture in the next empty cell, or report as overflow on a full chain
   task automatic sieve_step(input value_type value);
      sieve_result_type res;
      for (int slot = 0; slot < fill_count; slot++) begin
         // a cell holding zero only divides zero
         if (kept_prime[slot] == '0) begin
            if (value == '0) return;
         end else if (value % kept_prime[slot] == '0) begin
            return;
         end
      end
      res.prime_value = value;
      if (fill_count < CELLS) begin
         kept_prime[fill_count] = value;
         fill_count++;
         res.overflow = 1'b0;
      end else begin
         res.overflow = 1'b1;
      end
      expected_primes.push_back(res);
   endtask

   // ------------------------------------------------------------------------
   // driver: bursts of random length separated by random gaps; a stalled
   // item stays on the port unchanged
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      logic offer;
      offer = req_valid;
      if (reset) begin
         offer      = 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (req_valid && !req_stall) begin
         // item taken at this edge, predict its result now
         sieve_step(req_value);
         offer = 1'b0;
      end
      if (!reset && !offer && pending_candidates.size() != 0) begin
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_candidates[0].drain_first && expected_primes.size() != 0) begin
            // sender pause: let every outstanding result come out first
         end else begin
            req_value <= pending_candidates[0].value;
            pending_candidates.pop_front();
            offer = 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               // some bursts run back to back with no gap at all
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end else begin
               burst_left--;
            end
         end
      end
      req_valid <= offer;
   end

   // ------------------------------------------------------------------------
   // monitor and receiver: checks each result against the oldest prediction,
   // then picks the stall for the next cycle
   // ------------------------------------------------------------------------
   int   result_count = 0;
   int   hold_left    = 0;
   logic hold_done    = 1'b0;
   int   stall_mode   = 0;
   int   mode_left    = 0;

   always @(posedge clock) begin
      sieve_result_type want;
      logic             stall_next;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_primes.size() == 0) begin
            $display("%0t: unexpected result prime_value=%0d overflow=%0b",
                     $time, rsp_prime_value, rsp_overflow);
            error_count++;
         end else begin
            want = expected_primes.pop_front();
            if (rsp_prime_value !== want.prime_value) begin
               $display("%0t: prime_value mismatch expected=%0d actual=%0d",
                        $time, want.prime_value, rsp_prime_value);
               error_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow mismatch expected=%0b actual=%0b",
                        $time, want.overflow, rsp_overflow);
               error_count++;
            end
         end
         result_count++;
      end

      if (reset) begin
         stall_next = 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (!hold_done && result_count == 60) begin
         // long hold-off: the output register fills and the input backs up
         hold_left  = HOLD_CYCLES;
         hold_done  = 1'b1;
         stall_next = 1'b1;
      end else begin
         // stall pattern switches between never, light and heavy stalling
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 3) == 0);
            default: stall_next = ($urandom_range(0, 3) != 0);
         endcase
      end
      rsp_stall <= stall_next;
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      value_type     directed[$];
      value_type     odd_primes[15];
      candidate_type cand;
      int            pick;
      int            factor;

      // zero first: the empty chain captures it, and a repeated zero is then
      // dropped by the cell holding zero; the primes up to 47 fill the rest,
      // with the composite 4 dropped on the way
      directed = '{16'd0, 16'd0, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd11,
                   16'd13, 16'd17, 16'd19, 16'd23, 16'd29, 16'd31, 16'd37,
                   16'd41, 16'd43, 16'd47,
                   // full chain: one passes everything, zero is dropped,
                   // a repeated prime overflows twice, top values
                   16'd1, 16'd0, 16'd53, 16'd53, 16'd65535, 16'd65521, 16'd32768};
      foreach (directed[i]) begin
         cand.value       = directed[i];
         cand.drain_first = 1'b0;
         pending_candidates.push_back(cand);
      end

      odd_primes = '{16'd3, 16'd5, 16'd7, 16'd11, 16'd13, 16'd17, 16'd19, 16'd23,
                     16'd29, 16'd31, 16'd37, 16'd41, 16'd43, 16'd47, 16'd53};
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: cand.value = VALUE_WIDTH'($urandom_range(0, 65535));
            // odd numbers get past the cell holding two
            4, 5: cand.value = VALUE_WIDTH'($urandom_range(0, 65535)) | 16'd1;
            // multiples of the odd primes from 3 to 53
            6, 7: begin
               factor     = $urandom_range(0, 14);
               cand.value = VALUE_WIDTH'(odd_primes[factor]
                            * $urandom_range(1, 65535 / odd_primes[factor]));
            end
            8: cand.value = VALUE_WIDTH'($urandom_range(0, 120));
            default: cand.value = VALUE_WIDTH'($urandom_range(65000, 65535));
         endcase
         cand.drain_first = (n == 800);
         pending_candidates.push_back(cand);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_candidates.size() != 0 || req_valid) @(posedge clock);
      while (expected_primes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_primes.size() == 0) begin
         $display("** pipelined_prime_sieve: PASSED **");
      end else begin
         $display("** pipelined_prime_sieve: FAILED **");
      end
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #30_000_000;
      $display("** pipelined_prime_sieve: FAILED **");
      $finish;
   end

endmodule : pipelined_prime_sieve_test
